@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/arl_pkg.sv @@
// types, constants and codes for the address range lookup block
package arl_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W        = 32;
    localparam int ENTRY_INDEX_W = 10;
    localparam int ENTRY_COUNT_W = 11;
    localparam int STATUS_W      = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_TABLE  = 2'd2;

    localparam logic [PADDR_W-1:0] REG_ENTRY_COUNT = 3'd0;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [ADDR_W-1:0] name_off;
    } slot_t;

    typedef struct packed {
        logic write;
        logic start;
        logic step;
        logic emit_found;
        logic emit_miss;
        logic emit_empty;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic more;
        logic count_zero;
        logic out_full;
    } dp_status_t;

endpackage

@@ src/arl_dpath.sv @@
// range table memory, search bounds, probe compare and result register
module arl_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  arl_pkg::ctrl_cmd_t                cmd,
    output arl_pkg::dp_status_t               sts,
    input  logic [arl_pkg::ENTRY_COUNT_W-1:0] entry_count,
    input  logic [arl_pkg::ENTRY_INDEX_W-1:0] entry_index,
    input  logic [arl_pkg::ADDR_W-1:0]        entry_start,
    input  logic [arl_pkg::ADDR_W-1:0]        entry_end,
    input  logic [arl_pkg::ADDR_W-1:0]        entry_name_offset,
    input  logic [arl_pkg::ADDR_W-1:0]        lookup_addr,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [arl_pkg::STATUS_W-1:0]      status,
    output logic [arl_pkg::ADDR_W-1:0]        range_start,
    output logic [arl_pkg::ADDR_W-1:0]        name_offset
);
    import arl_pkg::*;

    slot_t                mem [TABLE_DEPTH];
    slot_t                rd_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 slot_ok;
    slot_t                wr_slot;

    logic [CNT_W-1:0]     count_c;
    logic [CNT_W-1:0]     count_m1;
    logic [IDX_W-1:0]     init_mid;

    logic [ADDR_W-1:0]    addr_reg;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     lo_next;
    logic [CNT_W-1:0]     hi1_reg;
    logic [CNT_W-1:0]     hi1_next;
    logic [IDX_W-1:0]     mid_reg;
    logic [IDX_W-1:0]     mid_next;
    logic [CNT_W-1:0]     mid_ext;
    logic [CNT_W:0]       mid_sum;
    logic                 below;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [ADDR_W-1:0]    range_start_reg;
    logic [ADDR_W-1:0]    name_offset_reg;

    // entry count clamped to the table size
    assign count_c  = (entry_count > ENTRY_COUNT_W'(TABLE_DEPTH)) ?
                      CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);
    assign count_m1 = count_c - CNT_W'(1);
    assign init_mid = IDX_W'(count_m1 >> 1);

    // one probe: compare against the entry read at mid
    assign mid_ext  = CNT_W'(mid_reg);
    assign below    = addr_reg < rd_reg.start_addr;
    assign lo_next  = below ? lo_reg : mid_ext + CNT_W'(1);
    assign hi1_next = below ? mid_ext : hi1_reg;
    assign mid_sum  = {1'b0, lo_next} + {1'b0, hi1_next} - (CNT_W + 1)'(1);
    assign mid_next = IDX_W'(mid_sum >> 1);

    always_comb
    begin
        if (cmd.start)
        begin
            rd_addr = init_mid;
        end
        else if (cmd.step)
        begin
            rd_addr = mid_next;
        end
        else
        begin
            rd_addr = mid_reg;
        end
    end

    assign slot_ok            = int'(entry_index) < TABLE_DEPTH;
    assign wr_slot.start_addr = entry_start;
    assign wr_slot.end_addr   = entry_end;
    assign wr_slot.name_off   = entry_name_offset;

    always_ff @(posedge clk)
    begin
        if (cmd.write && slot_ok)
        begin
            mem[entry_index[IDX_W-1:0]] <= wr_slot;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            addr_reg <= lookup_addr;
            lo_reg   <= '0;
            hi1_reg  <= count_c;
            mid_reg  <= init_mid;
        end
        else if (cmd.step)
        begin
            lo_reg   <= lo_next;
            hi1_reg  <= hi1_next;
            mid_reg  <= mid_next;
        end
    end

    assign sts.hit        = !below && (addr_reg < rd_reg.end_addr);
    assign sts.more       = lo_next < hi1_next;
    assign sts.count_zero = count_c == '0;
    assign sts.out_full   = out_valid_reg && !out_ready;

    // result register
    always_comb
    begin
        if (cmd.emit_found || cmd.emit_miss || cmd.emit_empty)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_found)
        begin
            status_reg      <= STATUS_FOUND;
            range_start_reg <= rd_reg.start_addr;
            name_offset_reg <= rd_reg.name_off;
        end
        else if (cmd.emit_miss)
        begin
            status_reg      <= STATUS_NOT_FOUND;
            range_start_reg <= '0;
            name_offset_reg <= '0;
        end
        else if (cmd.emit_empty)
        begin
            status_reg      <= STATUS_NO_TABLE;
            range_start_reg <= '0;
            name_offset_reg <= '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign range_start = range_start_reg;
    assign name_offset = name_offset_reg;

endmodule

@@ src/arl_ctrl.sv @@
// controller state machine for loads and the binary search
module arl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  arl_pkg::dp_status_t sts,
    output arl_pkg::ctrl_cmd_t  cmd
);
    import arl_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == ACTION_LOAD)
                    begin
                        cmd.write = 1'b1;
                    end
                    else if (sts.count_zero)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (sts.hit)
                begin
                    if (!sts.out_full)
                    begin
                        cmd.emit_found = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (!sts.more)
                begin
                    if (!sts.out_full)
                    begin
                        cmd.emit_miss = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_EMPTY:
            begin
                if (!sts.out_full)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/address_range_table_lookup_top.sv @@
// top level of the address range lookup block: config register, controller, datapath
//
// Holds up to 1024 address ranges, each a start, an exclusive end and a name
// offset, in a table memory with one write port and one read port. A load beat
// writes one entry. A lookup beat runs a binary search over
// the first entry_count entries, one probe per cycle on the table memory's read
// port, at most 11 probes for a full table; the block takes no new beat until
// the result is in the output register, and waits while that register is full.
// An empty table answers with a no-table status. A finished result waits in the
// output register while loads go on. The user writes entry_count over the APB port
// at addresses 0 to 3 only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module address_range_table_lookup_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [arl_pkg::PADDR_W-1:0]       paddr,
    input  logic [arl_pkg::PDATA_W-1:0]       pwdata,
    output logic [arl_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [arl_pkg::ENTRY_INDEX_W-1:0] entry_index,
    input  logic [arl_pkg::ADDR_W-1:0]        entry_start,
    input  logic [arl_pkg::ADDR_W-1:0]        entry_end,
    input  logic [arl_pkg::ADDR_W-1:0]        entry_name_offset,
    input  logic [arl_pkg::ADDR_W-1:0]        lookup_addr,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [arl_pkg::STATUS_W-1:0]      status,
    output logic [arl_pkg::ADDR_W-1:0]        range_start,
    output logic [arl_pkg::ADDR_W-1:0]        name_offset
);
    import arl_pkg::*;

    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                     cfg_hit;
    ctrl_cmd_t                cmd;
    dp_status_t               sts;
    logic                     emit_any;
    logic                     in_beat;
    logic                     result_zero;

    assign pready  = 1'b1;
    assign cfg_hit = paddr[PADDR_W-1] == REG_ENTRY_COUNT[PADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            entry_count_reg <= pwdata[ENTRY_COUNT_W-1:0];
        end
    end

    assign prdata = cfg_hit ? PDATA_W'(entry_count_reg) : '0;

    arl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    arl_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .entry_count       (entry_count_reg),
        .entry_index       (entry_index),
        .entry_start       (entry_start),
        .entry_end         (entry_end),
        .entry_name_offset (entry_name_offset),
        .lookup_addr       (lookup_addr),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .range_start       (range_start),
        .name_offset       (name_offset)
    );

    assign emit_any    = cmd.emit_found || cmd.emit_miss || cmd.emit_empty;
    assign in_beat     = in_valid && in_ready;
    assign result_zero = (range_start == '0) && (name_offset == '0);

    // no result is produced in a cycle that takes a beat
    `ASSERT_IMPLIES(a_emit_not_idle, clk, rst_n, emit_any, !in_ready)
    // a lookup keeps the block busy for the next cycle
    `ASSERT_NEXT(a_lookup_busy, clk, rst_n, in_beat && (action == ACTION_LOOKUP), !in_ready)
    // a miss or an empty table carries zero fields
    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, out_valid && (status != STATUS_FOUND), result_zero)
    // every emitted result shows up as a valid beat
    `ASSERT_NEXT(a_emit_valid, clk, rst_n, emit_any, out_valid)

endmodule
